### hdl/twba_pkg.sv
// Package for the time-walk block averager: payload structs, state words,
// FSM state enum and fixed constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package twba_pkg;

  localparam int AMPLITUDE_BITS = 12;
  localparam int TIME_BITS      = 16;
  localparam int SUM_BITS       = 48;
  localparam int ASUM_BITS      = 28;

  localparam logic [1:0]  CFG_BLOCK_LENGTH = 2'd0;
  localparam logic [1:0]  CFG_TIME_SCALE   = 2'd1;
  localparam logic        OP_READING       = 1'b0;
  localparam logic        OP_LOAD          = 1'b1;
  localparam logic [15:0] BLOCK_LENGTH_RST = 16'd1000;
  localparam logic [15:0] TIME_SCALE_RST   = 16'd26;

  typedef struct packed {
    logic               opcode;
    logic [2:0]         channel;
    logic [11:0]        amplitude;
    logic [15:0]        hit_time;
    logic [15:0]        ref_time;
    logic signed [31:0] walk_gain;
    logic signed [31:0] walk_offset;
  } twba_in_t;

  typedef struct packed {
    logic [2:0]         out_channel;
    logic [11:0]        mean_amplitude;
    logic signed [31:0] mean_time;
    logic [15:0]        block_number;
  } twba_out_t;

  // per-channel accumulator word
  typedef struct packed {
    logic signed [SUM_BITS-1:0] time_sum;
    logic [ASUM_BITS-1:0]       amp_sum;
    logic [15:0]                count;
    logic [15:0]                blk;
  } twba_acc_t;

  typedef struct packed {
    logic signed [31:0] gain;
    logic signed [31:0] offset;
  } twba_coef_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RCP,
    ST_SQRT,
    ST_MUL,
    ST_ACC,
    ST_DIVT,
    ST_DIVA,
    ST_EMIT
  } twba_state_e;

endpackage
`default_nettype wire

### hdl/twba_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none
module twba_div #(
  parameter int NW = 48,
  parameter int DW = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic               busy_o,
  output logic               done_o,
  output logic [NW-1:0]      quot_o
);
  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt_q;
  logic          done_q;
  logic [NW-1:0] num_q;
  logic [DW-1:0] den_q;
  logic [DW-1:0] rem_q;
  logic [DW:0]   rem_sh;
  logic          geq;
  logic [DW:0]   rem_n;

  always_comb begin
    rem_sh = {rem_q, num_q[NW-1]};
    geq    = rem_sh >= {1'b0, den_q};
    rem_n  = geq ? (rem_sh - {1'b0, den_q}) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CW'(NW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      num_q <= {num_q[NW-2:0], geq};
      rem_q <= rem_n[DW-1:0];
    end
  end

  assign busy_o = cnt_q != '0;
  assign done_o = done_q;
  assign quot_o = num_q;
endmodule
`default_nettype wire

### hdl/twba_isqrt.sv
// Digit-by-digit integer square root, two radicand bits per cycle.
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none
module twba_isqrt #(
  parameter int XW = 34
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [XW-1:0] x_i,
  output logic               done_o,
  output logic [XW/2-1:0]    root_o
);
  localparam int RW = XW / 2;
  localparam int CW = $clog2(RW + 1);

  logic [CW-1:0] cnt_q;
  logic          done_q;
  logic [XW-1:0] x_q;
  logic [RW-1:0] root_q;
  logic [RW:0]   rem_q;
  logic [RW+2:0] rem_sh;
  logic [RW+2:0] trial;
  logic          geq;
  logic [RW+2:0] rem_n;

  always_comb begin
    rem_sh = {rem_q, x_q[XW-1:XW-2]};
    trial  = {1'b0, root_q, 2'b01};
    geq    = rem_sh >= trial;
    rem_n  = geq ? (rem_sh - trial) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CW'(RW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= x_i;
      root_q <= '0;
      rem_q  <= '0;
    end else if (cnt_q != '0) begin
      x_q    <= {x_q[XW-3:0], 2'b00};
      root_q <= {root_q[RW-2:0], geq};
      rem_q  <= rem_n[RW:0];
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule
`default_nettype wire

### hdl/pmt_time_walk_block_average_top.sv
// Time-walk corrected block averager, top level: config registers, the two
// channel memories, sequencer and output register. Uses twba_pkg, twba_div,
// twba_isqrt.
//
// Usage:
//  - in channel: one beat is one item (reading or coefficient load).
//    in_ready_o is high only while the sequencer is idle.
//  - cfg channel: always ready; index 0 = block_length, 1 = time_scale.
//    Write only while the block is idle.
//  - out channel: one beat per completed block, held in an output register,
//    so a stalled receiver blocks only the next emitting reading.
//  - Load beats and out-of-range channels leave the sequencer idle.
//  - A reading runs the 48-step reciprocal divide, the 17-step square root,
//    the multiply state and the accumulate state before in_ready_o returns.
//    A reading that completes a block adds two more 48-step divides for the
//    means, plus any wait for the output register to drain. The divider is
//    shared between the reciprocal and both means.
//  - Reset clears the per-entry valid bits, so all channels read as zero
//    accumulators and zero coefficients; no clearing pass is needed.
//  - Accumulator entries are read-modified-written and coefficient entries
//    written one item at a time, so accesses to one entry never overlap.
`timescale 1ns / 1ps
`default_nettype none
module pmt_time_walk_block_average_top #(
  parameter int CHANNELS = 6
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire twba_pkg::twba_in_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output twba_pkg::twba_out_t      out_data_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [15:0]         cfg_data_i
);
  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SB = twba_pkg::SUM_BITS;
  localparam int AB = twba_pkg::ASUM_BITS;

  // Configuration registers
  logic [15:0] blen_q, scale_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blen_q  <= twba_pkg::BLOCK_LENGTH_RST;
      scale_q <= twba_pkg::TIME_SCALE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        twba_pkg::CFG_BLOCK_LENGTH: blen_q  <= cfg_data_i;
        twba_pkg::CFG_TIME_SCALE:   scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input decode
  twba_pkg::twba_state_e state_q, state_d;
  logic in_acc, ch_ok, is_load, rd_go, ld_go;
  logic [AW-1:0] in_addr;

  assign in_ready_o = state_q == twba_pkg::ST_IDLE;
  assign in_acc     = in_valid_i && in_ready_o;
  assign ch_ok      = 32'(in_data_i.channel) < CHANNELS;
  assign is_load    = in_data_i.opcode == twba_pkg::OP_LOAD;
  assign rd_go      = in_acc && ch_ok && !is_load;
  assign ld_go      = in_acc && ch_ok && is_load;
  assign in_addr    = AW'(in_data_i.channel);

  // Memories: coefficients and accumulators, registered read
  twba_pkg::twba_coef_t coef_mem [CHANNELS];
  twba_pkg::twba_acc_t  acc_mem  [CHANNELS];
  logic [CHANNELS-1:0]  coef_vld_q, acc_vld_q;
  twba_pkg::twba_coef_t coef_rd_q, coef;
  twba_pkg::twba_acc_t  acc_rd_q, acc;
  logic                 coef_rv_q, acc_rv_q;
  logic                 acc_we;
  twba_pkg::twba_acc_t  acc_wd;
  logic [AW-1:0]        addr_q;

  always_ff @(posedge clk_i) begin
    if (ld_go) coef_mem[in_addr] <= '{gain: in_data_i.walk_gain,
                                      offset: in_data_i.walk_offset};
    if (rd_go) coef_rd_q <= coef_mem[in_addr];
    if (acc_we) acc_mem[addr_q] <= acc_wd;
    if (rd_go) acc_rd_q <= acc_mem[in_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_vld_q <= '0;
      acc_vld_q  <= '0;
      coef_rv_q  <= 1'b0;
      acc_rv_q   <= 1'b0;
    end else begin
      if (ld_go) coef_vld_q[in_addr] <= 1'b1;
      if (acc_we) acc_vld_q[addr_q] <= 1'b1;
      if (rd_go) begin
        coef_rv_q <= coef_vld_q[in_addr];
        acc_rv_q  <= acc_vld_q[in_addr];
      end
    end
  end

  assign coef = coef_rv_q ? coef_rd_q : '0;
  assign acc  = acc_rv_q ? acc_rd_q : '0;

  // Item registers
  logic [2:0]                     ch_q;
  logic [twba_pkg::AMPLITUDE_BITS-1:0] amp_q;
  logic [twba_pkg::TIME_BITS-1:0] hit_q, ref_q;

  always_ff @(posedge clk_i) begin
    if (rd_go) begin
      ch_q   <= in_data_i.channel;
      addr_q <= in_addr;
      amp_q  <= in_data_i.amplitude[twba_pkg::AMPLITUDE_BITS-1:0];
      hit_q  <= in_data_i.hit_time[twba_pkg::TIME_BITS-1:0];
      ref_q  <= in_data_i.ref_time[twba_pkg::TIME_BITS-1:0];
    end
  end

  // Shared divider
  logic        div_start, div_busy, div_done;
  logic [47:0] div_num, div_quot;
  logic [15:0] div_den;
  logic [twba_pkg::AMPLITUDE_BITS-1:0] amp_clamp;

  assign amp_clamp = (in_data_i.amplitude[twba_pkg::AMPLITUDE_BITS-1:0] == '0) ?
                     twba_pkg::AMPLITUDE_BITS'(1) :
                     in_data_i.amplitude[twba_pkg::AMPLITUDE_BITS-1:0];

  twba_div #(.NW(48), .DW(16)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  logic        sq_start, sq_done;
  logic [16:0] sq_root;

  twba_isqrt #(.XW(34)) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .x_i     ({1'b0, div_quot[32:0]}),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  // Multiply stage: c1 * r and (hit - ref) * scale
  logic signed [49:0] prod_q;
  logic signed [33:0] scaled_q;
  logic signed [16:0] diff;
  assign diff = $signed({1'b0, hit_q}) - $signed({1'b0, ref_q});

  always_ff @(posedge clk_i) begin
    if (state_q == twba_pkg::ST_MUL) begin
      prod_q   <= coef.gain * $signed({1'b0, sq_root});
      scaled_q <= diff * $signed({1'b0, scale_q});
    end
  end

  // Accumulate stage
  logic signed [50:0] walk_full;
  logic signed [28:0] walk;
  logic signed [49:0] sum_w;
  logic signed [SB-1:0] sum_sat;
  logic [15:0] n_new, len;
  logic [AB-1:0] asum_new;
  logic emit;

  always_comb begin
    walk_full = 51'(prod_q) + 51'($signed({coef.offset, 16'h0000}));
    walk      = walk_full[50:22];
    sum_w     = 50'(acc.time_sum) + 50'(scaled_q) - 50'(walk);
    if (sum_w > $signed(50'(SB'({1'b0, {(SB-1){1'b1}}}))))
      sum_sat = {1'b0, {(SB-1){1'b1}}};
    else if (sum_w < 50'($signed({1'b1, {(SB-1){1'b0}}})))
      sum_sat = {1'b1, {(SB-1){1'b0}}};
    else
      sum_sat = sum_w[SB-1:0];
    asum_new = acc.amp_sum + AB'(amp_q);
    n_new    = acc.count + 16'd1;
    len      = (blen_q == '0) ? 16'd1 : blen_q;
    emit     = n_new >= len;
  end

  // Block result registers
  logic          neg_q;
  logic [15:0]   n_q, blk_q;
  logic [AB-1:0] asum_q;
  logic signed [31:0] mt_q;
  logic [SB-1:0] mag;
  assign mag = sum_sat[SB-1] ? SB'(-sum_sat) : SB'(sum_sat);

  always_ff @(posedge clk_i) begin
    if (state_q == twba_pkg::ST_ACC) begin
      neg_q  <= sum_sat[SB-1];
      n_q    <= n_new;
      asum_q <= asum_new;
      blk_q  <= acc.blk;
    end
    if (state_q == twba_pkg::ST_DIVT && div_done) begin
      if (neg_q)
        mt_q <= (div_quot > 48'h0000_8000_0000) ? 32'sh8000_0000 : -$signed(div_quot[31:0]);
      else
        mt_q <= (div_quot > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(div_quot[31:0]);
    end
  end

  // Output register
  logic      out_valid_q, emit_go;
  twba_pkg::twba_out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_go) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // whole beat loaded at once; the amplitude quotient is still held by the
  // idle divider in ST_EMIT
  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      out_q <= '{out_channel: ch_q, mean_amplitude: div_quot[11:0],
                 mean_time: mt_q, block_number: blk_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= twba_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    sq_start  = 1'b0;
    acc_we    = 1'b0;
    acc_wd    = '{time_sum: sum_sat, amp_sum: asum_new, count: n_new, blk: acc.blk};
    emit_go   = 1'b0;
    case (state_q)
      twba_pkg::ST_IDLE: begin
        if (rd_go) begin
          div_start = 1'b1;
          div_num   = 48'h0001_0000_0000;
          div_den   = 16'(amp_clamp);
          state_d   = twba_pkg::ST_RCP;
        end
      end
      twba_pkg::ST_RCP: begin
        if (div_done) begin
          sq_start = 1'b1;
          state_d  = twba_pkg::ST_SQRT;
        end
      end
      twba_pkg::ST_SQRT: begin
        if (sq_done) state_d = twba_pkg::ST_MUL;
      end
      twba_pkg::ST_MUL: begin
        state_d = twba_pkg::ST_ACC;
      end
      twba_pkg::ST_ACC: begin
        acc_we = 1'b1;
        if (emit) begin
          acc_wd    = '{time_sum: '0, amp_sum: '0, count: '0, blk: acc.blk + 16'd1};
          div_start = 1'b1;
          div_num   = mag;
          div_den   = n_new;
          state_d   = twba_pkg::ST_DIVT;
        end else begin
          state_d = twba_pkg::ST_IDLE;
        end
      end
      twba_pkg::ST_DIVT: begin
        if (div_done) begin
          div_start = 1'b1;
          div_num   = 48'(asum_q);
          div_den   = n_q;
          state_d   = twba_pkg::ST_DIVA;
        end
      end
      twba_pkg::ST_DIVA: begin
        if (div_done) state_d = twba_pkg::ST_EMIT;
      end
      twba_pkg::ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          emit_go = 1'b1;
          state_d = twba_pkg::ST_IDLE;
        end
      end
      default: state_d = twba_pkg::ST_IDLE;
    endcase
  end

  // Checks
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_go |=> out_valid_o)
    else $error("emitted block not presented");

  a_wb_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_we |-> !in_ready_o)
    else $error("accumulator write-back while accepting");

  a_blk_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == twba_pkg::ST_ACC && emit) |=> (state_q == twba_pkg::ST_DIVT))
    else $error("block completion not followed by mean divide");

endmodule
`default_nettype wire

### dv/tb_pmt_time_walk_block_average_top.sv
// Testbench for pmt_time_walk_block_average_top: drives readings and
// coefficient loads, predicts block means in a local model, checks outputs.
// Depends on twba_pkg and the top-level RTL.
`timescale 1ns / 1ps
module tb_pmt_time_walk_block_average_top;

  localparam int NCH       = 6;
  localparam int WDOG_MAX  = 20000;
  localparam int DRAIN_CYC = 400;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  twba_pkg::twba_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  twba_pkg::twba_out_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  pmt_time_walk_block_average_top #(.CHANNELS(NCH)) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Local model of the averager: mirrors the block's per-channel state.
  // ---------------------------------------------------------------------
  logic [15:0]        mdl_block_len;
  logic [15:0]        mdl_scale;
  logic signed [31:0] mdl_gain   [NCH];
  logic signed [31:0] mdl_offset [NCH];
  logic signed [47:0] mdl_tsum   [NCH];
  logic [27:0]        mdl_asum   [NCH];
  logic [15:0]        mdl_count  [NCH];
  logic [15:0]        mdl_blk    [NCH];

  twba_pkg::twba_out_t block_means_q[$];   // expected block results, oldest first
  int        n_errors;
  int        n_beats_in;
  int        n_blocks_out;
  int        n_loads;
  int        idle_cycles;
  bit        burst_mode;         // sender uses bursts/gaps when set

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic model_reset();
    mdl_block_len = twba_pkg::BLOCK_LENGTH_RST;
    mdl_scale     = twba_pkg::TIME_SCALE_RST;
    for (int i = 0; i < NCH; i++) begin
      mdl_gain[i] = '0; mdl_offset[i] = '0; mdl_tsum[i] = '0;
      mdl_asum[i] = '0; mdl_count[i] = '0;  mdl_blk[i] = '0;
    end
  endtask

  // Update per-channel state for one accepted beat; queue a result if the
  // beat closes a block.
  task automatic predict_block(input twba_pkg::twba_in_t it);
    longint signed   diff, walk, corr, sum, mean, prod;
    longint unsigned recip, amp, len, cnt;
    int              ch;
    twba_pkg::twba_out_t res;
    ch = it.channel;
    if (ch >= NCH) return;
    if (it.opcode == twba_pkg::OP_LOAD) begin
      mdl_gain[ch]   = it.walk_gain;
      mdl_offset[ch] = it.walk_offset;
      return;
    end
    amp   = it.amplitude;
    diff  = longint'(it.hit_time) - longint'(it.ref_time);
    recip = int_sqrt((64'd1 << 32) / ((amp == 0) ? 64'd1 : amp));
    prod  = longint'(mdl_gain[ch]) * longint'(recip) + longint'(mdl_offset[ch]) * 65536;
    walk  = prod >>> 22;  // arithmetic shift is floor
    corr  = diff * longint'(mdl_scale) - walk;
    sum   = longint'(mdl_tsum[ch]) + corr;
    if (sum > 64'sh7FFF_FFFF_FFFF) sum = 64'sh7FFF_FFFF_FFFF;
    if (sum < -64'sh8000_0000_0000) sum = -64'sh8000_0000_0000;
    mdl_tsum[ch]  = sum[47:0];
    mdl_asum[ch]  = mdl_asum[ch] + 28'(amp);
    mdl_count[ch] = mdl_count[ch] + 16'd1;
    len = (mdl_block_len == 0) ? 1 : mdl_block_len;
    cnt = mdl_count[ch];
    if (cnt < len) return;
    mean = longint'(mdl_tsum[ch]) / longint'(cnt);
    if (mean > 64'sh7FFF_FFFF) mean = 64'sh7FFF_FFFF;
    if (mean < -64'sh8000_0000) mean = -64'sh8000_0000;
    res.out_channel    = 3'(ch);
    res.mean_amplitude = 12'(longint'(mdl_asum[ch]) / longint'(cnt));
    res.mean_time      = mean[31:0];
    res.block_number   = mdl_blk[ch];
    block_means_q = {block_means_q, res};
    mdl_blk[ch]   = mdl_blk[ch] + 16'd1;
    mdl_tsum[ch]  = '0;
    mdl_asum[ch]  = '0;
    mdl_count[ch] = '0;
  endtask

  // ---------------------------------------------------------------------
  // Result checker and receiver stall pattern
  // ---------------------------------------------------------------------
  int stall_mode;  // 0: none, 1: random, 2: long periodic
  int stall_phase;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (block_means_q.size() == 0) begin
          $display("%0t ERROR: unexpected result, actual %p", $time, out_data);
          n_errors++;
        end else begin
          twba_pkg::twba_out_t exp_r;
          exp_r = block_means_q.pop_front();
          n_blocks_out++;
          if (out_data.out_channel !== exp_r.out_channel) begin
            $display("%0t ERROR out_channel: expected %0d actual %0d", $time,
                     exp_r.out_channel, out_data.out_channel);
            n_errors++;
          end
          if (out_data.mean_amplitude !== exp_r.mean_amplitude) begin
            $display("%0t ERROR mean_amplitude: expected %0d actual %0d", $time,
                     exp_r.mean_amplitude, out_data.mean_amplitude);
            n_errors++;
          end
          if (out_data.mean_time !== exp_r.mean_time) begin
            $display("%0t ERROR mean_time: expected %0d actual %0d", $time,
                     exp_r.mean_time, out_data.mean_time);
            n_errors++;
          end
          if (out_data.block_number !== exp_r.block_number) begin
            $display("%0t ERROR block_number: expected %0d actual %0d", $time,
                     exp_r.block_number, out_data.block_number);
            n_errors++;
          end
        end
      end
      stall_phase <= stall_phase + 1;
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 2) != 0);
        default: out_ready <= ((stall_phase % 97) > 60);
      endcase
    end
  end

  // Watchdog: cycles with no beat accepted on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG_MAX) begin
      $display("Watchdog expired at %0t", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sender helpers
  // ---------------------------------------------------------------------
  int burst_left;

  // Send one beat; valid held until accepted and left up for the next beat
  // of a burst. Gaps and pauses drop valid first.
  task automatic send_item(input twba_pkg::twba_in_t it);
    int gap;
    if (burst_mode) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 8);
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_block(it);
    n_beats_in++;
    if (it.opcode == twba_pkg::OP_LOAD) n_loads++;
  endtask

  // Wait for all expected results, then let the sequencer settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (block_means_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == twba_pkg::CFG_BLOCK_LENGTH) mdl_block_len = val;
    else if (idx == twba_pkg::CFG_TIME_SCALE) mdl_scale = val;
  endtask

  function automatic twba_pkg::twba_in_t reading(int ch, int amp, int hit, int rt);
    twba_pkg::twba_in_t it;
    it.opcode      = twba_pkg::OP_READING;
    it.channel     = 3'(ch);
    it.amplitude   = 12'(amp);
    it.hit_time    = 16'(hit);
    it.ref_time    = 16'(rt);
    it.walk_gain   = 32'($urandom);
    it.walk_offset = 32'($urandom);
    return it;
  endfunction

  function automatic twba_pkg::twba_in_t coef_load(int ch, logic [31:0] g,
                                                  logic [31:0] o);
    twba_pkg::twba_in_t it;
    it             = reading(ch, $urandom, $urandom, $urandom);
    it.opcode      = twba_pkg::OP_LOAD;
    it.walk_gain   = g;
    it.walk_offset = o;
    return it;
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  // Field extremes, zero amplitude, loads, ignored channels, block lengths 1 and 0.
  task automatic test_directed();
    write_reg(twba_pkg::CFG_BLOCK_LENGTH, 16'd1);
    send_item(reading(0, 0, 0, 0));
    send_item(reading(1, 4095, 16'hFFFF, 0));
    send_item(reading(2, 1, 0, 16'hFFFF));
    send_item(coef_load(3, 32'h7FFF_FFFF, 32'h8000_0000));
    send_item(reading(3, 0, 100, 200));
    send_item(reading(3, 4095, 100, 200));
    send_item(coef_load(4, 32'h8000_0000, 32'h7FFF_FFFF));
    send_item(reading(4, 0, 16'hFFFF, 0));
    send_item(coef_load(5, 32'hFFFF_FFFF, 32'h0001_0000));
    send_item(reading(5, 2048, 16'h5555, 16'hAAAA));
    send_item(reading(6, 7, 7, 7));      // out of range: ignored
    send_item(reading(7, 4095, 1, 2));   // out of range: ignored
    send_item(coef_load(7, 32'h1234_5678, 32'h9ABC_DEF0));
    write_reg(twba_pkg::CFG_TIME_SCALE, 16'hFFFF);
    send_item(reading(1, 4095, 16'hFFFF, 0));
    send_item(reading(2, 0, 0, 16'hFFFF));
    write_reg(twba_pkg::CFG_BLOCK_LENGTH, 16'd0);  // behaves as one
    send_item(reading(0, 3000, 16'hAAAA, 16'h5555));
    write_reg(twba_pkg::CFG_TIME_SCALE, 16'd0);
    send_item(reading(4, 17, 1000, 9));
  endtask

  // Drive the time sum hard to both signs: saturation of the block mean.
  task automatic test_saturation();
    write_reg(twba_pkg::CFG_TIME_SCALE, 16'hFFFF);
    write_reg(twba_pkg::CFG_BLOCK_LENGTH, 16'd4);
    send_item(coef_load(0, 32'h8000_0000, 32'h8000_0000));
    send_item(coef_load(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    for (int i = 0; i < 4; i++) begin
      send_item(reading(0, 1, 16'hFFFF, 0));
      send_item(reading(1, 1, 0, 16'hFFFF));
    end
  endtask

  // Lower block length mid-block: next reading closes with actual count.
  task automatic test_length_drop();
    write_reg(twba_pkg::CFG_TIME_SCALE, twba_pkg::TIME_SCALE_RST);
    write_reg(twba_pkg::CFG_BLOCK_LENGTH, 16'd8);
    for (int i = 0; i < 5; i++) send_item(reading(2, $urandom, $urandom, $urandom));
    write_reg(twba_pkg::CFG_BLOCK_LENGTH, 16'd2);
    send_item(reading(2, $urandom, $urandom, $urandom));
  endtask

  // Random traffic over several settings; mostly readings with loads mixed in.
  task automatic test_random(input int n_items);
    twba_pkg::twba_in_t it;
    int       phase;
    phase = 0;
    for (int k = 0; k < n_items; k++) begin
      if (k % 140 == 0) begin
        case (phase % 5)
          0: write_reg(twba_pkg::CFG_BLOCK_LENGTH, 16'd3);
          1: write_reg(twba_pkg::CFG_BLOCK_LENGTH, 16'($urandom_range(1, 6)));
          2: write_reg(twba_pkg::CFG_TIME_SCALE, 16'($urandom));
          3: write_reg(twba_pkg::CFG_BLOCK_LENGTH, 16'hFFFF);
          default: write_reg(twba_pkg::CFG_BLOCK_LENGTH, 16'd2);
        endcase
        stall_mode = phase % 3;
        burst_mode = (phase % 4) != 1;
        phase++;
      end
      if (k == 350) begin
        // sender holds off until every expected block has arrived
        in_valid <= 1'b0;
        @(posedge clk);
        while (block_means_q.size() != 0) @(posedge clk);
      end
      it = reading($urandom_range(0, 7), $urandom, $urandom, $urandom);
      if ($urandom_range(0, 3) == 0) it.amplitude = 12'($urandom_range(0, 3));
      if ($urandom_range(0, 9) == 0) begin
        it.opcode = twba_pkg::OP_LOAD;
        if ($urandom_range(0, 1)) it.walk_gain = 32'($signed($urandom_range(0, 200000)) - 100000);
      end
      if ($urandom_range(0, 19) == 0) it.channel = 3'($urandom_range(6, 7));
      send_item(it);
    end
  endtask

  initial begin
    in_valid    = 1'b0;
    in_data     = '0;
    out_ready   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = twba_pkg::CFG_BLOCK_LENGTH;
    cfg_data    = '0;
    n_errors    = 0;
    n_beats_in  = 0;
    n_blocks_out = 0;
    n_loads     = 0;
    idle_cycles = 0;
    stall_mode  = 0;
    stall_phase = 0;
    burst_mode  = 1'b0;
    burst_left  = 0;
    model_reset();
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    burst_mode = 1'b1;
    stall_mode = 1;
    test_saturation();
    test_length_drop();
    test_random(700);
    drain();

    $display("Covered %0d input beats (%0d coefficient loads), %0d block results checked,",
             n_beats_in, n_loads, n_blocks_out);
    $display("across block lengths 0..65535 and time scales 0..65535 with stalls.");
    if (n_errors == 0 && block_means_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### pmt_time_walk_block_average_top.f
hdl/twba_pkg.sv
hdl/twba_div.sv
hdl/twba_isqrt.sv
hdl/pmt_time_walk_block_average_top.sv
dv/tb_pmt_time_walk_block_average_top.sv
